// File: rtl/rpy_pkg.sv
// Package for the roll-pitch-yaw to rotation matrix unit.
// Holds widths, fixed-point constants, the arctangent table and beat types.
// No dependencies.
package rpy_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_WIDTH   = 16;
    localparam int ENTRY_WIDTH   = 16;
    localparam int Q_INT         = 30;
    localparam int ANGLE_FRAC    = ANGLE_WIDTH - 3;
    localparam int ENTRY_FRAC    = ENTRY_WIDTH - 2;
    localparam int QW            = 34;

    localparam logic signed [QW-1:0] PI_Q      = 34'sd3373259426;
    localparam logic signed [QW-1:0] HALF_PI_Q = 34'sd1686629713;
    localparam logic signed [QW-1:0] GAIN_INV_Q = 34'sd652032874;

    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
    typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
    typedef logic signed [QW-1:0]          q_t;

    typedef struct packed {
        angle_t roll;
        angle_t pitch;
        angle_t yaw;
    } rpy_in_t;

    typedef struct packed {
        entry_t r00;
        entry_t r01;
        entry_t r02;
        entry_t r10;
        entry_t r11;
        entry_t r12;
        entry_t r20;
        entry_t r21;
        entry_t r22;
    } rpy_out_t;

    function automatic q_t atan_q(input int i);
        q_t r;
        r = '0;
        unique case (i)
            0:  r = 34'sh03243F6A8;
            1:  r = 34'sh01DAC6705;
            2:  r = 34'sh00FADBAFC;
            3:  r = 34'sh007F56EA6;
            4:  r = 34'sh003FEAB76;
            5:  r = 34'sh001FFD55B;
            6:  r = 34'sh000FFFAAA;
            7:  r = 34'sh0007FFF55;
            8:  r = 34'sh0003FFFEA;
            9:  r = 34'sh0001FFFFD;
            10: r = 34'sh0000FFFFF;
            11: r = 34'sh00007FFFF;
            12: r = 34'sh00003FFFF;
            13: r = 34'sh00001FFFF;
            14: r = 34'sh00000FFFF;
            15: r = 34'sh000007FFF;
            16: r = 34'sh000003FFF;
            17: r = 34'sh000001FFF;
            18: r = 34'sh000000FFF;
            19: r = 34'sh0000007FF;
            20: r = 34'sh0000003FF;
            21: r = 34'sh0000001FF;
            22: r = 34'sh0000000FF;
            23: r = 34'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Product of two Q30 values, rounded half up back to Q30.
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [2*QW-1:0] p;
        p = a * b + (68'sd1 <<< (Q_INT - 1));
        return q_t'(p >>> Q_INT);
    endfunction

    function automatic entry_t to_entry(input q_t v);
        q_t r;
        q_t one;
        one = q_t'(1) <<< ENTRY_FRAC;
        r = (v + (q_t'(1) <<< (Q_INT - ENTRY_FRAC - 1))) >>> (Q_INT - ENTRY_FRAC);
        if (r > one)
        begin
            r = one;
        end
        if (r < -one)
        begin
            r = -one;
        end
        return entry_t'(r);
    endfunction

endpackage

// File: rtl/rpy_stream_if.sv
// Valid/ready stream interface carrying one beat of payload type T.
// No dependencies; the payload type is the parameter T.
interface rpy_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rpy_to_rotation_matrix_unit.sv
// Roll-pitch-yaw to rotation matrix: three CORDICs and the closed-form products.
// Depends on rpy_pkg and rpy_stream_if.
// Throughput: one beat per cycle while the sink takes beats; a valid stage holds while its successor is stalled.
// Reset clears all stage valid bits; payload registers are not reset.
module rpy_to_rotation_matrix_unit
    import rpy_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rpy_stream_if.sink   in_ch,
    rpy_stream_if.source out_ch
);

    localparam int NS = CORDIC_STAGES + 6;

    typedef struct packed {
        q_t  x;
        q_t  y;
        q_t  z;
        logic flip;
    } cord_t;

    typedef struct packed {
        q_t sr; q_t cr; q_t sp; q_t cp; q_t sy; q_t cy;
        q_t cysp; q_t sysp;
        q_t t00; q_t t01a; q_t t01b; q_t t02a; q_t t02b;
        q_t t10; q_t t11a; q_t t11b; q_t t12a; q_t t12b;
        q_t t21; q_t t22;
    } prod_t;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    cord_t    c_reg  [0:CORDIC_STAGES][0:2];
    cord_t    c_next [0:CORDIC_STAGES][0:2];
    prod_t    p_reg  [0:3];
    prod_t    p_next [0:3];
    rpy_out_t o_reg;
    rpy_out_t o_next;

    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || out_ch.ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign in_ch.ready  = adv[0];
    assign out_ch.valid = v_reg[NS-1];
    assign out_ch.data  = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_ch.valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Stage 0: clamp and fold each angle into the CORDIC range.
    always_comb
    begin
        angle_t a [0:2];
        q_t     z;
        a[0] = in_ch.data.roll;
        a[1] = in_ch.data.pitch;
        a[2] = in_ch.data.yaw;
        for (int k = 0; k < 3; k++)
        begin
            z = q_t'(a[k]) <<< (Q_INT - ANGLE_FRAC);
            if (z > PI_Q)
            begin
                z = PI_Q;
            end
            if (z < -PI_Q)
            begin
                z = -PI_Q;
            end
            c_next[0][k].flip = 1'b0;
            if (z > HALF_PI_Q)
            begin
                z = z - PI_Q;
                c_next[0][k].flip = 1'b1;
            end
            else if (z < -HALF_PI_Q)
            begin
                z = z + PI_Q;
                c_next[0][k].flip = 1'b1;
            end
            c_next[0][k].x = GAIN_INV_Q;
            c_next[0][k].y = '0;
            c_next[0][k].z = z;
        end

        // CORDIC micro-rotations, one per stage.
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_next[i+1][k].flip = c_reg[i][k].flip;
                if (!c_reg[i][k].z[QW-1])
                begin
                    c_next[i+1][k].x = c_reg[i][k].x - (c_reg[i][k].y >>> i);
                    c_next[i+1][k].y = c_reg[i][k].y + (c_reg[i][k].x >>> i);
                    c_next[i+1][k].z = c_reg[i][k].z - atan_q(i);
                end
                else
                begin
                    c_next[i+1][k].x = c_reg[i][k].x + (c_reg[i][k].y >>> i);
                    c_next[i+1][k].y = c_reg[i][k].y - (c_reg[i][k].x >>> i);
                    c_next[i+1][k].z = c_reg[i][k].z + atan_q(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= CORDIC_STAGES; i++)
        begin
            if (adv[i])
            begin
                c_reg[i] <= c_next[i];
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            if (adv[CORDIC_STAGES + 1 + j])
            begin
                p_reg[j] <= p_next[j];
            end
        end
        if (adv[NS-1])
        begin
            o_reg <= o_next;
        end
    end

    // Product stages: sign fix, first products, second products, sums, then rounding and saturation to entries.
    always_comb
    begin
        cord_t f [0:2];
        for (int k = 0; k < 3; k++)
        begin
            f[k] = c_reg[CORDIC_STAGES][k];
            if (f[k].flip)
            begin
                f[k].x = -f[k].x;
                f[k].y = -f[k].y;
            end
        end
        p_next[0] = '0;
        p_next[0].sr = f[0].y;
        p_next[0].cr = f[0].x;
        p_next[0].sp = f[1].y;
        p_next[0].cp = f[1].x;
        p_next[0].sy = f[2].y;
        p_next[0].cy = f[2].x;

        p_next[1] = p_reg[0];
        p_next[1].cysp = qmul(p_reg[0].cy, p_reg[0].sp);
        p_next[1].sysp = qmul(p_reg[0].sy, p_reg[0].sp);
        p_next[1].t00  = qmul(p_reg[0].cy, p_reg[0].cp);
        p_next[1].t10  = qmul(p_reg[0].sy, p_reg[0].cp);
        p_next[1].t21  = qmul(p_reg[0].cp, p_reg[0].sr);
        p_next[1].t22  = qmul(p_reg[0].cp, p_reg[0].cr);
        p_next[1].t01b = qmul(p_reg[0].sy, p_reg[0].cr);
        p_next[1].t02b = qmul(p_reg[0].sy, p_reg[0].sr);
        p_next[1].t11b = qmul(p_reg[0].cy, p_reg[0].cr);
        p_next[1].t12b = qmul(p_reg[0].cy, p_reg[0].sr);

        p_next[2] = p_reg[1];
        p_next[2].t01a = qmul(p_reg[1].cysp, p_reg[1].sr);
        p_next[2].t02a = qmul(p_reg[1].cysp, p_reg[1].cr);
        p_next[2].t11a = qmul(p_reg[1].sysp, p_reg[1].sr);
        p_next[2].t12a = qmul(p_reg[1].sysp, p_reg[1].cr);

        p_next[3] = p_reg[2];
        p_next[3].t01a = p_reg[2].t01a - p_reg[2].t01b;
        p_next[3].t02a = p_reg[2].t02a + p_reg[2].t02b;
        p_next[3].t11a = p_reg[2].t11a + p_reg[2].t11b;
        p_next[3].t12a = p_reg[2].t12a - p_reg[2].t12b;
        p_next[3].sp   = -p_reg[2].sp;

        o_next.r00 = to_entry(p_reg[3].t00);
        o_next.r01 = to_entry(p_reg[3].t01a);
        o_next.r02 = to_entry(p_reg[3].t02a);
        o_next.r10 = to_entry(p_reg[3].t10);
        o_next.r11 = to_entry(p_reg[3].t11a);
        o_next.r12 = to_entry(p_reg[3].t12a);
        o_next.r20 = to_entry(p_reg[3].sp);
        o_next.r21 = to_entry(p_reg[3].t21);
        o_next.r22 = to_entry(p_reg[3].t22);
    end

endmodule

// File: tb/sv/tb_rpy_to_rotation_matrix_unit.sv
// Testbench for the roll-pitch-yaw to rotation matrix unit: random and directed angle beats,
// random source gaps and sink stalls, results checked against an in-bench predictor.
// Depends on rpy_pkg, rpy_stream_if and rpy_to_rotation_matrix_unit.
module tb_rpy_to_rotation_matrix_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rpy_pkg::*;

    typedef logic signed [63:0] wide_t;

    class matrix_scoreboard;
        rpy_out_t pending_matrices[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function wide_t rot_mul(wide_t a, wide_t b);
            wide_t p;
            p = a * b + (64'sd1 <<< 29);
            return p >>> 30;
        endfunction

        function entry_t entry_of(wide_t v);
            wide_t r;
            wide_t one;
            one = 64'sd1 <<< ENTRY_FRAC;
            r = (v + (64'sd1 <<< (29 - ENTRY_FRAC))) >>> (30 - ENTRY_FRAC);
            if (r > one)
            begin
                r = one;
            end
            if (r < -one)
            begin
                r = -one;
            end
            return entry_t'(r);
        endfunction

        function void sine_cosine(angle_t a, output wide_t s, output wide_t c);
            wide_t z;
            wide_t x;
            wide_t y;
            wide_t dx;
            wide_t dy;
            wide_t step;
            wide_t pi_q;
            wide_t half_pi;
            bit flip;
            pi_q = 64'sd3373259426;
            half_pi = 64'sd1686629713;
            z = wide_t'(a) <<< (30 - ANGLE_FRAC);
            if (z > pi_q)
            begin
                z = pi_q;
            end
            if (z < -pi_q)
            begin
                z = -pi_q;
            end
            flip = 0;
            if (z > half_pi)
            begin
                z = z - pi_q;
                flip = 1;
            end
            else if (z < -half_pi)
            begin
                z = z + pi_q;
                flip = 1;
            end
            x = 64'sd652032874;
            y = 0;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                step = wide_t'(atan_q(i));
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - step;
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + step;
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            s = y;
            c = x;
        endfunction

        function void note_angles(rpy_in_t a);
            wide_t sr, cr, sp, cp, sy, cy, cysp, sysp;
            rpy_out_t m;
            sine_cosine(a.roll, sr, cr);
            sine_cosine(a.pitch, sp, cp);
            sine_cosine(a.yaw, sy, cy);
            cysp = rot_mul(cy, sp);
            sysp = rot_mul(sy, sp);
            m.r00 = entry_of(rot_mul(cy, cp));
            m.r01 = entry_of(rot_mul(cysp, sr) - rot_mul(sy, cr));
            m.r02 = entry_of(rot_mul(cysp, cr) + rot_mul(sy, sr));
            m.r10 = entry_of(rot_mul(sy, cp));
            m.r11 = entry_of(rot_mul(sysp, sr) + rot_mul(cy, cr));
            m.r12 = entry_of(rot_mul(sysp, cr) - rot_mul(cy, sr));
            m.r20 = entry_of(-sp);
            m.r21 = entry_of(rot_mul(cp, sr));
            m.r22 = entry_of(rot_mul(cp, cr));
            pending_matrices.push_back(m);
        endfunction

        task report(string what, int got, int want);
            mismatches++;
            $display("mismatch %s: got %0d expected %0d", what, got, want);
        endtask

        task check_matrix(rpy_out_t m);
            rpy_out_t e;
            if (pending_matrices.size() == 0)
            begin
                report("unexpected beat", 0, 0);
                return;
            end
            e = pending_matrices.pop_front();
            if (m.r00 !== e.r00) report("r00", m.r00, e.r00);
            if (m.r01 !== e.r01) report("r01", m.r01, e.r01);
            if (m.r02 !== e.r02) report("r02", m.r02, e.r02);
            if (m.r10 !== e.r10) report("r10", m.r10, e.r10);
            if (m.r11 !== e.r11) report("r11", m.r11, e.r11);
            if (m.r12 !== e.r12) report("r12", m.r12, e.r12);
            if (m.r20 !== e.r20) report("r20", m.r20, e.r20);
            if (m.r21 !== e.r21) report("r21", m.r21, e.r21);
            if (m.r22 !== e.r22) report("r22", m.r22, e.r22);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int cycles = 0;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_cycles = 0;
    bit hold_go;
    bit hold_done = 1'b0;
    matrix_scoreboard board;

    rpy_stream_if #(.T(rpy_in_t)) in_ch ();
    rpy_stream_if #(.T(rpy_out_t)) out_ch ();

    rpy_to_rotation_matrix_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("** rpy_to_rotation_matrix_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            board.check_matrix(out_ch.data);
        end
        if (hold_go && !hold_done)
        begin
            hold_cycles <= 200;
            hold_done <= 1'b1;
            out_ch.ready <= 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic angle_t any_angle();
        int r;
        r = $urandom_range(9);
        if (r == 0)
        begin
            return angle_t'($urandom);
        end
        if (r == 1)
        begin
            return angle_t'($urandom_range(25736 + 200, 25736 - 200));
        end
        return angle_t'(int'($urandom_range(51472)) - 25736);
    endfunction

    task automatic send_angles(angle_t r, angle_t p, angle_t y);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= '{roll: r, pitch: p, yaw: y};
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        board.note_angles('{roll: r, pitch: p, yaw: y});
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
        begin
            send_angles(any_angle(), any_angle(), any_angle());
        end
    endtask

    initial
    begin
        angle_t edge_angles[11];
        int waited;
        rst_n = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_go = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        board = new();
        edge_angles = '{16'sh8000, 16'sh7FFF, -16'sd25736, 16'sd25736, 16'sd0, 16'sd12868,
                        -16'sd12868, 16'sd12869, -16'sd12869, 16'sd1, -16'sd1};
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int i = 0; i < 11; i++)
        begin
            send_angles(edge_angles[i], edge_angles[(i + 3) % 11], edge_angles[(i + 7) % 11]);
        end
        send_angles(16'sh5555, 16'shAAAA, 16'sh3333);
        send_angles(16'shAAAA, 16'sh5555, 16'shCCCC);
        send_random(400);
        src_idle_pct = 59;
        send_random(350);
        src_idle_pct = 0;
        sink_stall_pct = 59;
        send_random(350);
        hold_go = 1;
        send_random(100);
        src_idle_pct = 10;
        sink_stall_pct = 10;
        send_random(350);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_random(250);
        in_ch.valid <= 0;
        waited = 0;
        while (board.pending_matrices.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (CORDIC_STAGES + 20) @(posedge clk);
        if (board.mismatches == 0 && board.pending_matrices.size() == 0)
        begin
            $display("** rpy_to_rotation_matrix_unit: PASSED **");
        end
        else
        begin
            $display("** rpy_to_rotation_matrix_unit: FAILED **");
        end
        $finish;
    end
endmodule
